// ===== sv/utf8_bom_encoding_detector_macros.svh =====
// assertion macros for the encoding detector
`ifndef UTF8_BOM_ENCODING_DETECTOR_MACROS_SVH
`define UTF8_BOM_ENCODING_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// property must hold in the same cycle as its antecedent
`define UBED_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubed assertion failed");
// property must hold in the cycle after its antecedent
`define UBED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubed assertion failed");
`else
`define UBED_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define UBED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/ubed_pkg.sv =====
package ubed_pkg;

    // one input item as it travels through the pipeline
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_item;
    } t_item;

    // lead byte decode result
    typedef struct packed {
        logic       err;
        logic [2:0] cont;
    } t_lead;

    // verdict codes
    localparam logic [2:0] V_UTF8     = 3'd0;
    localparam logic [2:0] V_UTF8_BOM = 3'd1;
    localparam logic [2:0] V_UTF16LE  = 3'd2;
    localparam logic [2:0] V_UTF16BE  = 3'd3;
    localparam logic [2:0] V_UNKNOWN  = 3'd4;

    // byte values used in detection
    localparam logic [7:0] B_EF = 8'hEF;
    localparam logic [7:0] B_BB = 8'hBB;
    localparam logic [7:0] B_BF = 8'hBF;
    localparam logic [7:0] B_FF = 8'hFF;
    localparam logic [7:0] B_FE = 8'hFE;
    localparam logic [7:0] B_C2 = 8'hC2;
    localparam logic [7:0] B_DF = 8'hDF;
    localparam logic [7:0] B_F7 = 8'hF7;
    localparam logic [7:0] B_FB = 8'hFB;
    localparam logic [7:0] B_FD = 8'hFD;
    localparam logic [7:0] B_7F = 8'h7F;
    localparam logic [7:0] B_80 = 8'h80;

    // classify a lead byte: continuation count or error
    function automatic t_lead lead_decode(input logic [7:0] b);
        t_lead r;
        r.err  = 1'b0;
        r.cont = 3'd0;
        if (b <= B_7F) begin
            r.cont = 3'd0;
        end else if (b < B_C2) begin
            r.err = 1'b1;
        end else if (b <= B_DF) begin
            r.cont = 3'd1;
        end else if (b <= B_EF) begin
            r.cont = 3'd2;
        end else if (b <= B_F7) begin
            r.cont = 3'd3;
        end else if (b <= B_FB) begin
            r.cont = 3'd4;
        end else if (b <= B_FD) begin
            r.cont = 3'd5;
        end else begin
            r.err = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== sv/ubed_in_stage.sv =====
module ubed_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ubed_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_ready,
    output logic           o_valid,
    output ubed_pkg::t_item o_item
);
    import ubed_pkg::*;

    logic  r_valid;
    t_item r_item;

    // stage is free when empty or when its item moves on this cycle
    assign o_ready = !r_valid || i_advance;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== sv/ubed_scan.sv =====
module ubed_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  ubed_pkg::t_item i_item,
    output logic           o_result_valid,
    output logic [2:0]     o_verdict
);
    import ubed_pkg::*;

    logic [23:0] r_head;
    logic [1:0]  r_seen;
    logic [2:0]  r_cont;
    logic        r_inv;
    logic [23:0] n_head;
    logic [1:0]  n_seen;
    logic [2:0]  n_cont;
    logic        n_inv;
    t_lead       lead;
    logic [7:0]  b;

    assign b    = i_item.data_byte;
    assign lead = lead_decode(b);

    // next stream state after this item's byte
    always_comb begin
        n_head = r_head;
        n_seen = r_seen;
        n_cont = r_cont;
        n_inv  = r_inv;
        if (i_item.byte_present) begin
            case (r_seen)
                2'd0: n_head[7:0]   = b;
                2'd1: n_head[15:8]  = b;
                2'd2: n_head[23:16] = b;
                default: ;
            endcase
            if (r_seen != 2'd3) begin
                n_seen = r_seen + 2'd1;
            end
            if (r_cont == 3'd0) begin
                if (lead.err) begin
                    n_inv = 1'b1;
                end else begin
                    n_cont = lead.cont;
                end
            end else if (b < B_80 || b > B_BF) begin
                n_inv  = 1'b1;
                n_cont = 3'd0;
            end else begin
                n_cont = r_cont - 3'd1;
            end
        end
    end

    // verdict from the head bytes, mark first
    always_comb begin
        if (n_head[7:0] == B_EF && n_head[15:8] == B_BB && n_head[23:16] == B_BF) begin
            o_verdict = V_UTF8_BOM;
        end else if (n_head[7:0] == B_FF && n_head[15:8] == B_FE) begin
            o_verdict = V_UTF16LE;
        end else if (n_head[7:0] == B_FE && n_head[15:8] == B_FF) begin
            o_verdict = V_UTF16BE;
        end else if (n_inv) begin
            o_verdict = V_UNKNOWN;
        end else begin
            o_verdict = V_UTF8;
        end
    end

    assign o_result_valid = i_take && i_item.last_item;

    // stream state, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_seen <= '0;
            r_cont <= '0;
            r_inv  <= 1'b0;
        end else if (i_take) begin
            if (i_item.last_item) begin
                r_head <= '0;
                r_seen <= '0;
                r_cont <= '0;
                r_inv  <= 1'b0;
            end else begin
                r_head <= n_head;
                r_seen <= n_seen;
                r_cont <= n_cont;
                r_inv  <= n_inv;
            end
        end
    end
endmodule

// ===== sv/utf8_bom_encoding_detector.sv =====
// Byte stream encoding detector.
// Input channel s_axis: one byte per item. tdata carries the byte, tuser
// says whether the byte is present (0 on an item that only ends the stream),
// tlast marks the final item of a stream.
// Output channel m_axis: one verdict per stream, sent for the item with tlast:
// 0 UTF-8, 1 UTF-8 with byte order mark, 2 UTF-16LE mark, 3 UTF-16BE mark,
// 4 unknown (a malformed UTF-8 sequence was seen). Items without tlast give
// no output.
// A verdict becomes valid on m_axis once its last item has been accepted and
// has passed the input register, then the scan logic into the result register.
// Throughput: one item per cycle, while no last item waits for the result register.
// Reset (synchronous, active low) empties both registers and clears the
// stream state; the next byte starts a new stream.
// When m_axis stalls, the result register holds its verdict; items without
// tlast keep flowing, and a further last item waits in the input register,
// which then holds s_axis_tready low until the verdict is taken.
module utf8_bom_encoding_detector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] byte_present
    input  logic       s_axis_tlast,   // last_item
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] verdict, [7:3] zero
);
    import ubed_pkg::*;

`include "utf8_bom_encoding_detector_macros.svh"

    t_item      in_item;
    t_item      s1_item;
    logic       s1_valid;
    logic       s2_take;
    logic       out_free;
    logic       res_valid;
    logic [2:0] res_verdict;
    logic       r_out_valid;
    logic [2:0] r_out_verdict;

    assign in_item.data_byte    = s_axis_tdata;
    assign in_item.byte_present = s_axis_tuser;
    assign in_item.last_item    = s_axis_tlast;

    // output register can load when empty or being drained
    assign out_free = !r_out_valid || m_axis_tready;
    // a last item needs room for its verdict, others pass freely
    assign s2_take  = s1_valid && (!s1_item.last_item || out_free);

    ubed_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_item    (in_item),
        .i_advance (s2_take),
        .o_ready   (s_axis_tready),
        .o_valid   (s1_valid),
        .o_item    (s1_item)
    );

    ubed_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (s2_take),
        .i_item         (s1_item),
        .o_result_valid (res_valid),
        .o_verdict      (res_verdict)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out_verdict <= res_verdict;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_verdict};

    // checks
    `UBED_ASSERT_SAME(a_res_has_room, i_clk, i_rst_n, res_valid, out_free)
    `UBED_ASSERT_NEXT(a_res_loaded, i_clk, i_rst_n, res_valid, m_axis_tvalid)
    `UBED_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, s1_valid && !s2_take,
        s1_valid && $stable(s1_item))
    `UBED_ASSERT_SAME(a_verdict_range, i_clk, i_rst_n, m_axis_tvalid,
        r_out_verdict <= V_UNKNOWN)
endmodule
